>>> design/psc_pkg.sv
// Shared package for the PID servo position controller.
// Holds field widths, register indexes, reset values and the structs that
// pass between the configuration, state loop and drive datapath modules.
package psc_pkg;

    // Field widths
    localparam int ANGLE_W    = 16;
    localparam int ERR_W      = 17;
    localparam int GAIN_W     = 32;
    localparam int LIMIT_W    = 15;
    localparam int DBAND_W    = 10;
    localparam int INTEG_W    = 24;
    localparam int ACC_W      = 21;
    localparam int DRIVE_W    = 17;
    localparam int ILIM_W     = 22;
    localparam int OLIM_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Product and sum widths of the drive datapath
    localparam int PPROD_W = GAIN_W + ERR_W;
    localparam int IPROD_W = GAIN_W + INTEG_W;
    localparam int DPROD_W = GAIN_W + ACC_W;
    localparam int PSUM_W  = IPROD_W + 1;
    localparam int SUM_W   = PSUM_W + 1;
    localparam int FRAC_W  = 16;

    // Derivative window
    localparam int DIFF_WINDOW_DEF = 5;
    localparam int WINDOW_MAX      = 16;
    // Reciprocal scale for the window division: exact for every accumulator value
    localparam int DIV_SHIFT = ACC_W + $clog2(WINDOW_MAX) + 1;
    localparam int QPROD_W   = ACC_W + DIV_SHIFT;

    // Integral clamp is the drive limit times this factor
    localparam int ILIM_SCALE = 100;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KI      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KD      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DBAND   = 3'd5;

    // Reset values
    localparam int                 LIMIT_RST_VAL = 1000;
    localparam logic [LIMIT_W-1:0] LIMIT_RST     = LIMIT_W'(LIMIT_RST_VAL);
    localparam logic [ILIM_W-1:0]  ILIM_RST      = ILIM_W'(LIMIT_RST_VAL * ILIM_SCALE);
    localparam logic [OLIM_W-1:0]  OLIM_RST      = OLIM_W'(LIMIT_RST_VAL * 2);
    localparam logic [DBAND_W-1:0] DBAND_RST     = DBAND_W'(10);

    // Accumulator saturation bounds, one bit wider than the accumulator
    localparam logic signed [ACC_W:0] ACC_MAX = (ACC_W+1)'((1 <<< (ACC_W-1)) - 1);
    localparam logic signed [ACC_W:0] ACC_MIN = -(ACC_W+1)'(1 <<< (ACC_W-1));

    typedef struct packed {
        logic signed [ANGLE_W-1:0] target;
        logic signed [GAIN_W-1:0]  gain_prop;
        logic signed [GAIN_W-1:0]  gain_integ;
        logic signed [GAIN_W-1:0]  gain_deriv;
        logic [ILIM_W-1:0]         ilim;
        logic [OLIM_W-1:0]         olim;
        logic [DBAND_W-1:0]        dead_band;
    } t_cfg;

    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [ACC_W-1:0]   accum;
        logic                      wrap;
        logic                      dead;
    } t_loop_item;

endpackage

>>> design/pid_servo_position_controller.sv
// Top level of the PID servo position controller.
// Depends on psc_pkg, psc_cfg_regs, psc_loop and psc_drive.
//
//   Channel     Direction  Handshake            Payload
//   config      in         i_cfg_we             i_cfg_idx, i_cfg_data
//   sample      in         i_valid / o_ready    i_measured_angle
//   result      out        o_valid / i_ready    o_drive, o_in_dead_band
//
// One sample is accepted per clock cycle at full rate while results are
// taken. A result appears on o_valid once its sample has passed through
// an input register, a state update (the integral and difference
// accumulator recurrence, which sets the one-sample-per-cycle rate), two
// multiplier stages and the result register.
// Reset is synchronous and active low; it clears the controller state and
// loads the register reset values. A stalled result holds in the result
// register while earlier stages keep filling, so o_ready only drops once
// every stage is occupied and the result is not taken.
module pid_servo_position_controller #(
    parameter int DIFF_WINDOW = psc_pkg::DIFF_WINDOW_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [psc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [psc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [psc_pkg::ANGLE_W-1:0] i_measured_angle,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [psc_pkg::DRIVE_W-1:0] o_drive,
    output logic                               o_in_dead_band
);
    import psc_pkg::*;

    // Configuration as seen by both datapath modules
    t_cfg       cfg;
    // Transfer from the state loop into the drive datapath
    logic       item_valid;
    logic       item_ready;
    t_loop_item item;

    psc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Error, integral, accumulator and window count update here one sample
    // per cycle unless stalled, so the next sample always sees its state.
    psc_loop #(
        .DIFF_WINDOW (DIFF_WINDOW)
    ) u_loop (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_measured_angle (i_measured_angle),
        .i_cfg            (cfg),
        .o_item_valid     (item_valid),
        .i_item_ready     (item_ready),
        .o_item           (item)
    );

    // The drive path holds no feedback other than the filtered derivative,
    // which is only updated in sample order as items pass through it.
    psc_drive #(
        .DIFF_WINDOW (DIFF_WINDOW)
    ) u_drive (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (item_valid),
        .o_item_ready   (item_ready),
        .i_item         (item),
        .i_cfg          (cfg),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_drive        (o_drive),
        .o_in_dead_band (o_in_dead_band)
    );

endmodule

>>> design/psc_cfg_regs.sv
// Configuration register file of the PID servo position controller.
// Depends on psc_pkg; also keeps the integral and drive clamps precomputed.
module psc_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [psc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [psc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output psc_pkg::t_cfg                    o_cfg
);
    import psc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target     <= '0;
            r_cfg.gain_prop  <= '0;
            r_cfg.gain_integ <= '0;
            r_cfg.gain_deriv <= '0;
            r_cfg.ilim       <= ILIM_RST;
            r_cfg.olim       <= OLIM_RST;
            r_cfg.dead_band  <= DBAND_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TARGET: r_cfg.target     <= i_cfg_data[ANGLE_W-1:0];
                REG_KP:     r_cfg.gain_prop  <= i_cfg_data[GAIN_W-1:0];
                REG_KI:     r_cfg.gain_integ <= i_cfg_data[GAIN_W-1:0];
                REG_KD:     r_cfg.gain_deriv <= i_cfg_data[GAIN_W-1:0];
                REG_LIMIT: begin
                    r_cfg.ilim <= ILIM_W'(i_cfg_data[LIMIT_W-1:0]) * ILIM_W'(ILIM_SCALE);
                    r_cfg.olim <= {i_cfg_data[LIMIT_W-1:0], 1'b0};
                end
                REG_DBAND:  r_cfg.dead_band  <= i_cfg_data[DBAND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/psc_loop.sv
// Input register and controller state loop: error, clamped integral,
// difference accumulator, window counter and dead band decision.
// Depends on psc_pkg.
module psc_loop #(
    parameter int DIFF_WINDOW = psc_pkg::DIFF_WINDOW_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [psc_pkg::ANGLE_W-1:0] i_measured_angle,
    input  psc_pkg::t_cfg                     i_cfg,
    output logic                              o_item_valid,
    input  logic                              i_item_ready,
    output psc_pkg::t_loop_item               o_item
);
    import psc_pkg::*;

    localparam int CNT_W = $clog2(DIFF_WINDOW);

    logic                      r_v0;
    logic signed [ANGLE_W-1:0] r_meas;
    logic                      r_v1;
    t_loop_item                r_s1;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [ACC_W-1:0]   r_accum;
    logic signed [ERR_W-1:0]   r_last_err;
    logic [CNT_W-1:0]          r_wcount;

    logic                      s1_free;
    logic                      mv01;
    logic signed [ERR_W-1:0]   n_err;
    logic signed [INTEG_W:0]   n_isum;
    logic signed [INTEG_W:0]   ilim_pos;
    logic signed [INTEG_W:0]   ilim_neg;
    logic signed [INTEG_W-1:0] n_integ;
    logic signed [ERR_W:0]     n_adiff;
    logic signed [ACC_W:0]     n_asum;
    logic signed [ACC_W-1:0]   n_accum;
    logic [ERR_W-1:0]          n_mag;
    logic                      n_dead;
    logic                      n_wrap;
    t_loop_item                n_s1;

    assign s1_free = !r_v1 || i_item_ready;
    assign mv01    = r_v0 && s1_free;
    assign o_ready = !r_v0 || s1_free;

    assign n_err = $signed({i_cfg.target[ANGLE_W-1], i_cfg.target})
                 - $signed({r_meas[ANGLE_W-1], r_meas});

    // Integral with clamp to plus or minus the integral limit
    assign n_isum   = $signed({r_integ[INTEG_W-1], r_integ})
                    + $signed({{(INTEG_W+1-ERR_W){n_err[ERR_W-1]}}, n_err});
    assign ilim_pos = $signed({{(INTEG_W+1-ILIM_W){1'b0}}, i_cfg.ilim});
    assign ilim_neg = -ilim_pos;

    always_comb begin
        priority if (n_isum < ilim_neg) begin
            n_integ = ilim_neg[INTEG_W-1:0];
        end else if (n_isum > ilim_pos) begin
            n_integ = ilim_pos[INTEG_W-1:0];
        end else begin
            n_integ = n_isum[INTEG_W-1:0];
        end
    end

    // Difference accumulator, saturating
    assign n_adiff = $signed({n_err[ERR_W-1], n_err})
                   - $signed({r_last_err[ERR_W-1], r_last_err});
    assign n_asum  = $signed({r_accum[ACC_W-1], r_accum})
                   + $signed({{(ACC_W-ERR_W){n_adiff[ERR_W]}}, n_adiff});

    always_comb begin
        priority if (n_asum < ACC_MIN) begin
            n_accum = ACC_MIN[ACC_W-1:0];
        end else if (n_asum > ACC_MAX) begin
            n_accum = ACC_MAX[ACC_W-1:0];
        end else begin
            n_accum = n_asum[ACC_W-1:0];
        end
    end

    assign n_wrap = (r_wcount == CNT_W'(DIFF_WINDOW - 1));
    assign n_mag  = n_err[ERR_W-1] ? ERR_W'(-n_err) : ERR_W'(n_err);
    assign n_dead = (n_mag <= {{(ERR_W-DBAND_W){1'b0}}, i_cfg.dead_band});

    always_comb begin
        n_s1.err   = n_err;
        n_s1.integ = n_integ;
        n_s1.accum = n_accum;
        n_s1.wrap  = n_wrap;
        n_s1.dead  = n_dead;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0       <= 1'b0;
            r_v1       <= 1'b0;
            r_integ    <= '0;
            r_accum    <= '0;
            r_last_err <= '0;
            r_wcount   <= '0;
        end else begin
            if (i_valid && o_ready) begin
                r_v0 <= 1'b1;
            end else if (mv01) begin
                r_v0 <= 1'b0;
            end
            if (mv01) begin
                r_v1 <= 1'b1;
            end else if (i_item_ready) begin
                r_v1 <= 1'b0;
            end
            if (mv01) begin
                r_integ  <= n_integ;
                r_accum  <= n_wrap ? '0 : n_accum;
                r_wcount <= n_wrap ? '0 : r_wcount + 1'b1;
                if (!n_dead) begin
                    r_last_err <= n_err;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_meas <= i_measured_angle;
        end
        if (mv01) begin
            r_s1 <= n_s1;
        end
    end

    assign o_item_valid = r_v1;
    assign o_item       = r_s1;

`ifndef SYNTH
    a_wcount_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wcount <= CNT_W'(DIFF_WINDOW - 1))
        else $error("window counter ran past the window length");

    a_last_err_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mv01 && !n_dead |=> r_last_err == r_s1.err)
        else $error("previous error not taken from a sample outside the dead band");
`endif

endmodule

>>> design/psc_drive.sv
// Drive datapath: gain products, windowed derivative division, Q42.16 sum,
// truncation toward zero, drive clamp and the result register.
// Depends on psc_pkg.
module psc_drive #(
    parameter int DIFF_WINDOW = psc_pkg::DIFF_WINDOW_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_item_valid,
    output logic                               o_item_ready,
    input  psc_pkg::t_loop_item                i_item,
    input  psc_pkg::t_cfg                      i_cfg,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [psc_pkg::DRIVE_W-1:0] o_drive,
    output logic                               o_in_dead_band
);
    import psc_pkg::*;

    localparam logic [DIV_SHIFT-1:0] DIV_MULT =
        DIV_SHIFT'(((1 <<< DIV_SHIFT) + DIFF_WINDOW - 1) / DIFF_WINDOW);
    localparam int Q_W = SUM_W - FRAC_W;

    // Stage 2 registers
    logic                      r_v2;
    logic signed [PPROD_W-1:0] r_pprod;
    logic signed [IPROD_W-1:0] r_iprod;
    logic [QPROD_W-1:0]        r_qprod;
    logic                      r_qneg;
    logic                      r_wrap;
    logic                      r_dead2;
    // Stage 3 registers
    logic                      r_v3;
    logic signed [PSUM_W-1:0]  r_psum;
    logic signed [DPROD_W-1:0] r_dprod;
    logic                      r_dead3;
    logic signed [ACC_W-1:0]   r_dfilt;
    // Result register
    logic                      r_ov;
    logic signed [DRIVE_W-1:0] r_drive;
    logic                      r_dead_o;

    logic                      out_free;
    logic                      s3_free;
    logic                      mv3;
    logic                      mv2;
    logic [ACC_W-1:0]          amag;
    logic signed [PPROD_W-1:0] n_pprod;
    logic signed [IPROD_W-1:0] n_iprod;
    logic [QPROD_W-1:0]        n_qprod;
    logic [ACC_W-1:0]          qmag;
    logic signed [ACC_W-1:0]   n_dquot;
    logic signed [ACC_W-1:0]   n_dval;
    logic signed [DPROD_W-1:0] n_dprod;
    logic signed [PSUM_W-1:0]  n_psum;
    logic signed [SUM_W-1:0]   n_sum;
    logic signed [SUM_W-1:0]   n_biased;
    logic signed [Q_W-1:0]     n_q;
    logic signed [Q_W-1:0]     olim_pos;
    logic signed [Q_W-1:0]     olim_neg;
    logic signed [Q_W-1:0]     n_clamped;
    logic signed [DRIVE_W-1:0] n_drive;

    assign out_free     = !r_ov || i_ready;
    assign mv3          = r_v3 && out_free;
    assign s3_free      = !r_v3 || out_free;
    assign mv2          = r_v2 && s3_free;
    assign o_item_ready = !r_v2 || s3_free;

    // Stage 2: P and I products, reciprocal product for the window division
    assign amag    = i_item.accum[ACC_W-1] ? ACC_W'(-i_item.accum) : ACC_W'(i_item.accum);
    assign n_pprod = $signed(i_cfg.gain_prop) * $signed(i_item.err);
    assign n_iprod = $signed(i_cfg.gain_integ) * $signed(i_item.integ);
    assign n_qprod = QPROD_W'(amag) * QPROD_W'(DIV_MULT);

    // Stage 3: quotient sign, derivative selection, D product, P plus I
    assign qmag    = r_qprod[QPROD_W-1:DIV_SHIFT];
    assign n_dquot = r_qneg ? -$signed(qmag) : $signed(qmag);
    assign n_dval  = r_wrap ? n_dquot : r_dfilt;
    assign n_dprod = $signed(i_cfg.gain_deriv) * n_dval;
    assign n_psum  = $signed({{(PSUM_W-PPROD_W){r_pprod[PPROD_W-1]}}, r_pprod})
                   + $signed({r_iprod[IPROD_W-1], r_iprod});

    // Output stage: full sum, truncation toward zero, clamp
    assign n_sum    = $signed({r_psum[PSUM_W-1], r_psum})
                    + $signed({{(SUM_W-DPROD_W){r_dprod[DPROD_W-1]}}, r_dprod});
    assign n_biased = n_sum + $signed({{(SUM_W-FRAC_W){1'b0}},
                                       {FRAC_W{n_sum[SUM_W-1]}}});
    assign n_q      = n_biased[SUM_W-1:FRAC_W];
    assign olim_pos = $signed({{(Q_W-OLIM_W){1'b0}}, i_cfg.olim});
    assign olim_neg = -olim_pos;

    always_comb begin
        priority if (n_q < olim_neg) begin
            n_clamped = olim_neg;
        end else if (n_q > olim_pos) begin
            n_clamped = olim_pos;
        end else begin
            n_clamped = n_q;
        end
    end

    assign n_drive = r_dead3 ? '0 : n_clamped[DRIVE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_ov    <= 1'b0;
            r_dfilt <= '0;
        end else begin
            if (i_item_valid && o_item_ready) begin
                r_v2 <= 1'b1;
            end else if (mv2) begin
                r_v2 <= 1'b0;
            end
            if (mv2) begin
                r_v3 <= 1'b1;
            end else if (mv3) begin
                r_v3 <= 1'b0;
            end
            if (mv3) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            if (mv2 && r_wrap) begin
                r_dfilt <= n_dquot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item_valid && o_item_ready) begin
            r_pprod <= n_pprod;
            r_iprod <= n_iprod;
            r_qprod <= n_qprod;
            r_qneg  <= i_item.accum[ACC_W-1];
            r_wrap  <= i_item.wrap;
            r_dead2 <= i_item.dead;
        end
        if (mv2) begin
            r_psum  <= n_psum;
            r_dprod <= n_dprod;
            r_dead3 <= r_dead2;
        end
        if (mv3) begin
            r_drive  <= n_drive;
            r_dead_o <= r_dead3;
        end
    end

    assign o_valid        = r_ov;
    assign o_drive        = r_drive;
    assign o_in_dead_band = r_dead_o;

`ifndef SYNTH
    a_dead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_dead_o |-> r_drive == '0)
        else $error("drive not zero inside the dead band");

    a_drive_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mv3 |-> ($signed({{(Q_W-DRIVE_W){n_drive[DRIVE_W-1]}}, n_drive}) <= olim_pos)
             && ($signed({{(Q_W-DRIVE_W){n_drive[DRIVE_W-1]}}, n_drive}) >= olim_neg))
        else $error("drive outside twice the drive limit");
`endif

endmodule
